// ===== design/pulse_width_trigger_with_holdoff_defines.svh =====
// Assertion macros shared by the pulse width trigger RTL.
`ifndef PULSE_WIDTH_TRIGGER_WITH_HOLDOFF_DEFINES_SVH
`define PULSE_WIDTH_TRIGGER_WITH_HOLDOFF_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PWTH_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define PWTH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pwth_pkg.sv =====
// Types, register map and helper functions for the pulse width trigger.
`default_nettype none

package pwth_pkg;

	localparam int unsigned TICK_W = 32;
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned DIST_W = 16;
	localparam int unsigned IR_W   = 7;
	localparam int unsigned NUM_DIST = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// Register indexes (byte address = 4 * index).
	localparam logic [2:0] REG_RANGE_MIN  = 3'd0;
	localparam logic [2:0] REG_RANGE_MAX  = 3'd1;
	localparam logic [2:0] REG_WIDTH_MIN  = 3'd2;
	localparam logic [2:0] REG_WIDTH_MAX  = 3'd3;
	localparam logic [2:0] REG_HOLDOFF    = 3'd4;
	localparam logic [2:0] REG_IR_ENABLE  = 3'd5;
	localparam logic [2:0] REG_REARM_BACK = 3'd6;

	// Reset values.
	localparam logic [15:0] RST_RANGE_MIN  = 16'd200;
	localparam logic [15:0] RST_RANGE_MAX  = 16'd800;
	localparam logic [15:0] RST_WIDTH_MIN  = 16'd2;
	localparam logic [15:0] RST_WIDTH_MAX  = 16'd20;
	localparam logic [15:0] RST_HOLDOFF    = 16'd1500;
	localparam logic        RST_IR_ENABLE  = 1'b1;
	localparam logic [15:0] RST_REARM_BACK = 16'd1000;

	typedef struct packed {
		logic [15:0] range_min;
		logic [15:0] range_max;
		logic [15:0] width_min;
		logic [15:0] width_max;
		logic [15:0] holdoff_ticks;
		logic        ir_enable;
		logic [15:0] rearm_back;
	} pwth_cfg_t;

	// Early re-arm of the ultrasonic holdoff from the IR path.
	typedef struct packed {
		logic              fire;
		logic [TICK_W-1:0] stamp;
	} pwth_rearm_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
	endfunction

	function automatic logic in_width(input logic [CNT_W-1:0] c,
			input logic [15:0] lo, input logic [15:0] hi);
		return (c < hi) && (c > lo);
	endfunction

	// Wrap-safe elapsed time test.
	function automatic logic held_off(input logic [TICK_W-1:0] now,
			input logic [TICK_W-1:0] last, input logic [15:0] holdoff);
		logic [TICK_W-1:0] elapsed;
		elapsed = now - last;
		return elapsed < {{(TICK_W-16){1'b0}}, holdoff};
	endfunction

endpackage

`default_nettype wire

// ===== design/pwth_ultra.sv =====
// Ultrasonic path: window detect, pulse width count and holdoff.
`default_nettype none
`include "pulse_width_trigger_with_holdoff_defines.svh"

module pwth_ultra import pwth_pkg::*; #(
	parameter int unsigned SONAR_COUNT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  pwth_cfg_t         cfg,
	input  logic [TICK_W-1:0] now,
	input  logic [DIST_W-1:0] dists [NUM_DIST],
	input  pwth_rearm_t       rearm,
	output logic              fire
);

	logic [CNT_W-1:0]  count_q;
	logic [TICK_W-1:0] last_q;
	logic              held;
	logic              high;
	logic [CNT_W-1:0]  count_d;

	always_comb begin
		high = 1'b0;
		for (int i = 0; i < SONAR_COUNT; i++) begin
			if (dists[i] != '0 && dists[i] < cfg.range_max && dists[i] > cfg.range_min)
				high = 1'b1;
		end
	end

	assign held = held_off(now, last_q, cfg.holdoff_ticks);
	assign fire = !held && !high && in_width(count_q, cfg.width_min, cfg.width_max);

	always_comb begin
		if (held)
			count_d = count_q;
		else if (high)
			count_d = sat_inc(count_q);
		else
			count_d = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			last_q  <= '0;
		end else if (adv) begin
			count_q <= count_d;
			// IR fire overrides the ultrasonic stamp.
			if (rearm.fire)
				last_q <= rearm.stamp;
			else if (fire)
				last_q <= now;
		end
	end

	`PWTH_ASSERT_NEXT(a_holdoff_freezes_count, clk, arst_n, adv && held, count_q == $past(count_q), "count moved during holdoff")
	`PWTH_ASSERT_NEXT(a_fire_clears_count, clk, arst_n, adv && fire, count_q == '0, "count not cleared after fire")
	`PWTH_ASSERT_NEXT(a_rearm_wins, clk, arst_n, adv && rearm.fire, last_q == $past(rearm.stamp), "rearm stamp not taken")

endmodule

`default_nettype wire

// ===== design/pwth_ir.sv =====
// IR path: high count, holdoff stamp and fire with ultrasonic re-arm.
`default_nettype none
`include "pulse_width_trigger_with_holdoff_defines.svh"

module pwth_ir import pwth_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  pwth_cfg_t         cfg,
	input  logic [TICK_W-1:0] now,
	input  logic [IR_W-1:0]   ir_bits,
	output logic              fire,
	output pwth_rearm_t       rearm
);

	logic [CNT_W-1:0]  cnt_q;
	logic [TICK_W-1:0] last_q;
	logic              hit;
	logic [CNT_W-1:0]  cnt_inc;
	logic              stamp_now;
	logic [TICK_W-1:0] last_new;

	assign hit       = |ir_bits;
	assign cnt_inc   = sat_inc(cnt_q);
	assign stamp_now = in_width(cnt_inc, cfg.width_min, cfg.width_max);
	// Holdoff is judged against the stamp as updated by this very beat.
	assign last_new  = stamp_now ? now : last_q;
	assign fire      = cfg.ir_enable && hit && !held_off(now, last_new, cfg.holdoff_ticks);

	assign rearm.fire  = fire;
	assign rearm.stamp = now - {{(TICK_W-16){1'b0}}, cfg.rearm_back};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= '0;
		end else if (adv && cfg.ir_enable) begin
			if (hit) begin
				cnt_q <= cnt_inc;
				if (stamp_now)
					last_q <= now;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	`PWTH_ASSERT_NEXT(a_disabled_holds, clk, arst_n, adv && !cfg.ir_enable, $stable(cnt_q) && $stable(last_q), "IR state moved while disabled")
	`PWTH_ASSERT_NEXT(a_low_clears, clk, arst_n, adv && cfg.ir_enable && !hit, cnt_q == '0, "IR count not cleared")
	`PWTH_ASSERT_NEXT(a_count_saturates, clk, arst_n, adv && cfg.ir_enable && hit && cnt_q == CNT_MAX, cnt_q == CNT_MAX, "IR count wrapped")

endmodule

`default_nettype wire

// ===== design/pulse_width_trigger_with_holdoff.sv =====
// Top level: APB registers, input and result registers, both detection paths.
`default_nettype none

// Pulse width trigger with holdoff. Each input beat (tick time, up to four
// ultrasonic distances, seven IR bits) yields exactly one result beat with
// ultra_fire and ir_fire. One beat is taken every clock unless out_ready
// stalls the result; the input register loads at the accepting edge and
// hands it on to the result register once that frees up. The state update
// loop allows this: counters and time stamps are updated in the same cycle
// the result is computed, so the next beat sees them. The user must write
// APB registers only while no beat is in flight; the block does not enforce it.

module pulse_width_trigger_with_holdoff import pwth_pkg::*; #(
	parameter int unsigned SONAR_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input beat
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] now_ticks,
	input  logic [15:0] dist_a,
	input  logic [15:0] dist_b,
	input  logic [15:0] dist_c,
	input  logic [15:0] dist_d,
	input  logic [6:0]  ir_bits,
	// result beat
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ultra_fire,
	output logic        ir_fire,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	pwth_cfg_t         cfg_q;
	logic [2:0]        reg_idx;
	logic              apb_wr;

	logic              valid_s1;
	logic [TICK_W-1:0] now_s1;
	logic [DIST_W-1:0] dist_s1 [NUM_DIST];
	logic [IR_W-1:0]   ir_s1;
	logic              adv;

	logic              out_valid_q;
	logic              ultra_fire_q;
	logic              ir_fire_q;

	logic              ultra_fire_d;
	logic              ir_fire_d;
	pwth_rearm_t       rearm;

	// Register port
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign apb_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_min     <= RST_RANGE_MIN;
			cfg_q.range_max     <= RST_RANGE_MAX;
			cfg_q.width_min     <= RST_WIDTH_MIN;
			cfg_q.width_max     <= RST_WIDTH_MAX;
			cfg_q.holdoff_ticks <= RST_HOLDOFF;
			cfg_q.ir_enable     <= RST_IR_ENABLE;
			cfg_q.rearm_back    <= RST_REARM_BACK;
		end else if (apb_wr) begin
			unique case (reg_idx)
				REG_RANGE_MIN:  cfg_q.range_min     <= pwdata[15:0];
				REG_RANGE_MAX:  cfg_q.range_max     <= pwdata[15:0];
				REG_WIDTH_MIN:  cfg_q.width_min     <= pwdata[15:0];
				REG_WIDTH_MAX:  cfg_q.width_max     <= pwdata[15:0];
				REG_HOLDOFF:    cfg_q.holdoff_ticks <= pwdata[15:0];
				REG_IR_ENABLE:  cfg_q.ir_enable     <= pwdata[0];
				REG_REARM_BACK: cfg_q.rearm_back    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RANGE_MIN:  prdata = {16'd0, cfg_q.range_min};
			REG_RANGE_MAX:  prdata = {16'd0, cfg_q.range_max};
			REG_WIDTH_MIN:  prdata = {16'd0, cfg_q.width_min};
			REG_WIDTH_MAX:  prdata = {16'd0, cfg_q.width_max};
			REG_HOLDOFF:    prdata = {16'd0, cfg_q.holdoff_ticks};
			REG_IR_ENABLE:  prdata = {31'd0, cfg_q.ir_enable};
			REG_REARM_BACK: prdata = {16'd0, cfg_q.rearm_back};
			default:        prdata = '0;
		endcase
	end

	// Input register: advance into the result register when it frees up.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1     <= now_ticks;
			dist_s1[0] <= dist_a;
			dist_s1[1] <= dist_b;
			dist_s1[2] <= dist_c;
			dist_s1[3] <= dist_d;
			ir_s1      <= ir_bits;
		end
	end

	pwth_ultra #(
		.SONAR_COUNT(SONAR_COUNT)
	) u_ultra (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg_q),
		.now    (now_s1),
		.dists  (dist_s1),
		.rearm  (rearm),
		.fire   (ultra_fire_d)
	);

	pwth_ir u_ir (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.cfg     (cfg_q),
		.now     (now_s1),
		.ir_bits (ir_s1),
		.fire    (ir_fire_d),
		.rearm   (rearm)
	);

	// Result register: hold until the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ultra_fire_q <= ultra_fire_d;
			ir_fire_q    <= ir_fire_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign ultra_fire = ultra_fire_q;
	assign ir_fire    = ir_fire_q;

endmodule

`default_nettype wire

// ===== dv/tb_pulse_width_trigger_with_holdoff.sv =====
// Self-checking testbench for pulse_width_trigger_with_holdoff: random and directed beats.
`timescale 1ns / 1ps

import pwth_pkg::*;

typedef struct packed {
	logic ultra;
	logic ir;
} fire_t;

// Tracks detector state and holds the fire flags due for each accepted update.
class fire_scoreboard;
	logic [15:0] range_lo, range_hi, width_lo, width_hi, holdoff, rearm;
	logic        ir_on;
	logic [15:0] ultra_cnt, ir_cnt;
	logic [31:0] ultra_stamp, ir_stamp;
	fire_t       fires_due[$];
	int          mismatches;

	function new();
		range_lo    = RST_RANGE_MIN;
		range_hi    = RST_RANGE_MAX;
		width_lo    = RST_WIDTH_MIN;
		width_hi    = RST_WIDTH_MAX;
		holdoff     = RST_HOLDOFF;
		ir_on       = RST_IR_ENABLE;
		rearm       = RST_REARM_BACK;
		ultra_cnt   = '0;
		ir_cnt      = '0;
		ultra_stamp = '0;
		ir_stamp    = '0;
		mismatches  = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] word);
		case (idx)
		REG_RANGE_MIN:  range_lo = word[15:0];
		REG_RANGE_MAX:  range_hi = word[15:0];
		REG_WIDTH_MIN:  width_lo = word[15:0];
		REG_WIDTH_MAX:  width_hi = word[15:0];
		REG_HOLDOFF:    holdoff  = word[15:0];
		REG_IR_ENABLE:  ir_on    = word[0];
		REG_REARM_BACK: rearm    = word[15:0];
		default: ;
		endcase
	endfunction

	// Elapsed time wraps modulo 2^32.
	function bit blocked(logic [31:0] t, logic [31:0] stamp);
		logic [31:0] gone;
		gone = t - stamp;
		return gone < {16'd0, holdoff};
	endfunction

	function bit in_window(logic [15:0] c);
		return c > width_lo && c < width_hi;
	endfunction

	function logic [15:0] bump(logic [15:0] c);
		return (c == CNT_MAX) ? c : c + 16'd1;
	endfunction

	function void note_update(logic [31:0] t, logic [15:0] d0, d1, d2, d3, logic [6:0] ir);
		fire_t       f;
		logic [15:0] d[NUM_DIST];
		logic        near;
		f = '0;
		d[0] = d0;
		d[1] = d1;
		d[2] = d2;
		d[3] = d3;
		near = 1'b0;
		if (!blocked(t, ultra_stamp)) begin
			foreach (d[j])
				if (d[j] != 16'd0 && d[j] > range_lo && d[j] < range_hi)
					near = 1'b1;
			if (near) begin
				ultra_cnt = bump(ultra_cnt);
			end else begin
				if (in_window(ultra_cnt)) begin
					f.ultra = 1'b1;
					ultra_stamp = t;
				end
				ultra_cnt = '0;
			end
		end
		if (ir_on) begin
			if (ir != 7'd0) begin
				ir_cnt = bump(ir_cnt);
				if (in_window(ir_cnt))
					ir_stamp = t;
				// IR fire overrides any ultrasonic stamp from this same update
				if (!blocked(t, ir_stamp)) begin
					f.ir = 1'b1;
					ultra_stamp = t - {16'd0, rearm};
				end
			end else begin
				ir_cnt = '0;
			end
		end
		fires_due.push_back(f);
	endfunction

	function void check_fires(logic u, logic i);
		fire_t want;
		if (fires_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result beat with none due: ultra_fire=%0b ir_fire=%0b",
					$time, u, i);
			return;
		end
		want = fires_due.pop_front();
		if (u !== want.ultra) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: ultra_fire expected %0b got %0b", $time, want.ultra, u);
		end
		if (i !== want.ir) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: ir_fire expected %0b got %0b", $time, want.ir, i);
		end
	endfunction

	function int pending();
		return fires_due.size();
	endfunction
endclass

module tb_pulse_width_trigger_with_holdoff;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] now_ticks;
	logic [15:0] dist_a, dist_b, dist_c, dist_d;
	logic [6:0]  ir_bits;
	logic        out_valid;
	logic        out_ready;
	logic        ultra_fire;
	logic        ir_fire;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	fire_scoreboard sb;
	bit          tx_idle;
	bit          rx_idle;
	logic [31:0] tick_now;

	pulse_width_trigger_with_holdoff #(.SONAR_COUNT(NUM_DIST)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.now_ticks  (now_ticks),
		.dist_a     (dist_a),
		.dist_b     (dist_b),
		.dist_c     (dist_c),
		.dist_d     (dist_d),
		.ir_bits    (ir_bits),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ultra_fire (ultra_fire),
		.ir_fire    (ir_fire),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #5 clk = ~clk;

	task automatic send_update(input logic [31:0] t, input logic [15:0] d0, d1, d2, d3,
			input logic [6:0] ir);
		int gap;
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		now_ticks <= t;
		dist_a    <= d0;
		dist_b    <= d1;
		dist_c    <= d2;
		dist_d    <= d3;
		ir_bits   <= ir;
		do @(posedge clk); while (!in_ready);
		sb.note_update(t, d0, d1, d2, d3, ir);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		logic [31:0] word;
		word = $urandom();
		if (idx == REG_IR_ENABLE)
			word[0] = val[0];
		else
			word[15:0] = val;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.write_reg(idx, word);
	endtask

	task automatic apply_cfg(input logic [15:0] rmin, rmax, wmin, wmax, hold,
			input logic ir_en, input logic [15:0] back);
		drain_results();
		write_reg(REG_RANGE_MIN, rmin);
		write_reg(REG_RANGE_MAX, rmax);
		write_reg(REG_WIDTH_MIN, wmin);
		write_reg(REG_WIDTH_MAX, wmax);
		write_reg(REG_HOLDOFF, hold);
		write_reg(REG_IR_ENABLE, {15'd0, ir_en});
		write_reg(REG_REARM_BACK, back);
	endtask

	function automatic bit in_band(logic [15:0] v);
		return v > sb.range_lo && v < sb.range_hi;
	endfunction

	function automatic logic [15:0] miss_dist();
		logic [15:0] v;
		case ($urandom_range(0, 3))
		0: v = '0;
		1: v = 16'($urandom_range(0, sb.range_lo));
		2: v = 16'($urandom_range(sb.range_hi, 16'hffff));
		default: v = 16'($urandom_range(0, 16'hffff));
		endcase
		if (in_band(v))
			v = '0;
		return v;
	endfunction

	function automatic logic [15:0] hit_dist();
		if (int'(sb.range_hi) > int'(sb.range_lo) + 1)
			return 16'($urandom_range(int'(sb.range_lo) + 1, int'(sb.range_hi) - 1));
		return miss_dist();
	endfunction

	// Pulse lengths cluster on the width limits, capped to keep runs short.
	function automatic int pick_width();
		int w;
		case ($urandom_range(0, 4))
		0: w = int'(sb.width_lo);
		1: w = int'(sb.width_lo) + 1;
		2: w = int'(sb.width_hi) - 1;
		3: w = int'(sb.width_hi);
		default: w = $urandom_range(1, 12);
		endcase
		if (w > 40)
			w = $urandom_range(1, 40);
		if (w < 0)
			w = 0;
		return w;
	endfunction

	task automatic run_traffic(input int n);
		int          pulse_left, ir_left, pause_at, step_max, j;
		logic [15:0] dv[4];
		logic [6:0]  ir;
		pulse_left = 0;
		ir_left    = 0;
		pause_at   = $urandom_range(0, n - 1);
		step_max   = (sb.holdoff == 16'd0) ? 40 : int'(sb.holdoff) / 3 + 1;
		for (int i = 0; i < n; i++) begin
			if (i == pause_at)
				drain_results();
			if ($urandom_range(0, 49) == 0)
				tick_now = $urandom();
			else
				tick_now += $urandom_range(0, step_max);
			if ($urandom_range(0, 99) < 8) begin
				for (j = 0; j < 4; j++)
					dv[j] = 16'($urandom_range(0, 16'hffff));
				ir = 7'($urandom_range(0, 127));
			end else begin
				for (j = 0; j < 4; j++)
					dv[j] = miss_dist();
				if (pulse_left > 0) begin
					pulse_left--;
					for (j = 0; j < 4; j++)
						if ($urandom_range(0, 1))
							dv[j] = hit_dist();
					dv[$urandom_range(0, 3)] = hit_dist();
				end else if ($urandom_range(0, 1)) begin
					pulse_left = pick_width();
				end
				if (ir_left > 0) begin
					ir_left--;
					ir = 7'($urandom_range(1, 127));
				end else begin
					ir = '0;
					if ($urandom_range(0, 2) == 0)
						ir_left = pick_width();
				end
			end
			send_update(tick_now, dv[0], dv[1], dv[2], dv[3], ir);
		end
	endtask

	task automatic directed_updates();
		send_update(32'd0,    16'd500, 16'd500, 16'd500, 16'd500, 7'h00);
		send_update(32'd1500, 16'd201, 16'd0, 16'd0, 16'd0, 7'h00);
		send_update(32'd1501, 16'd0, 16'd799, 16'd0, 16'd0, 7'h00);
		send_update(32'd1502, 16'd0, 16'd0, 16'd500, 16'd0, 7'h00);
		send_update(32'd1503, 16'd200, 16'd800, 16'd0, 16'hffff, 7'h00);
		send_update(32'd1600, 16'd500, 16'd0, 16'd0, 16'd0, 7'h00);
		send_update(32'd3003, 16'd0, 16'd0, 16'd0, 16'd500, 7'h00);
		send_update(32'd3004, 16'd0, 16'd0, 16'd0, 16'd0, 7'h00);
		send_update(32'd3005, 16'd0, 16'd0, 16'd0, 16'd0, 7'h7f);
		send_update(32'd3006, 16'd0, 16'd0, 16'd0, 16'd0, 7'h01);
		send_update(32'd3007, 16'd0, 16'd0, 16'd0, 16'd0, 7'h40);
		send_update(32'd3008, 16'd0, 16'd0, 16'd0, 16'd0, 7'h00);
		// tick counter wraps in the middle of a pulse
		send_update(32'hffff_fff0, 16'd500, 16'd0, 16'd0, 16'd0, 7'h00);
		send_update(32'hffff_fff1, 16'd500, 16'd0, 16'd0, 16'd0, 7'h00);
		send_update(32'hffff_fff2, 16'd500, 16'd0, 16'd0, 16'd0, 7'h00);
		send_update(32'h0000_0005, 16'd0, 16'd0, 16'd0, 16'd0, 7'h00);
		send_update(32'h0000_0100, 16'd500, 16'd0, 16'd0, 16'd0, 7'h00);
		// ultrasonic pulse ends on the same update that IR fires
		send_update(32'h0000_2000, 16'd500, 16'd0, 16'd0, 16'd0, 7'h00);
		send_update(32'h0000_2001, 16'd0, 16'd500, 16'd0, 16'd0, 7'h00);
		send_update(32'h0000_2002, 16'd0, 16'd0, 16'd500, 16'd0, 7'h00);
		send_update(32'h0000_2003, 16'd0, 16'd0, 16'd0, 16'd0, 7'h02);
		send_update(32'h0000_2004, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 7'h7f);
		send_update(32'hffff_ffff, 16'd1, 16'd1, 16'd1, 16'd1, 7'h00);
		tick_now = 32'hffff_ffff;
	endtask

	// Result side: random stalls, check every accepted beat.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_idle ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_fires(ultra_fire, ir_fire);
		end
	end

	initial begin
		logic [15:0] rmin, rmax, wmin, wmax;
		sb        = new();
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		now_ticks = '0;
		dist_a    = '0;
		dist_b    = '0;
		dist_c    = '0;
		dist_d    = '0;
		ir_bits   = '0;
		out_ready = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		tx_idle   = 1'b1;
		rx_idle   = 1'b1;
		tick_now  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_updates();

		apply_cfg(16'd0, 16'hffff, 16'd0, 16'hffff, 16'd0, 1'b1, 16'd0);
		run_traffic(100);
		// empty windows, IR path off
		apply_cfg(16'hffff, 16'd0, 16'hffff, 16'd0, 16'hffff, 1'b0, 16'hffff);
		run_traffic(60);
		for (int p = 0; p < 5; p++) begin
			rmin = 16'($urandom_range(0, 700));
			rmax = 16'(rmin + $urandom_range(0, 900));
			wmin = 16'($urandom_range(0, 4));
			wmax = 16'(wmin + $urandom_range(0, 14));
			apply_cfg(rmin, rmax, wmin, wmax, 16'($urandom_range(0, 400)),
				$urandom_range(0, 3) != 0, 16'($urandom_range(0, 16'hffff)));
			tx_idle = (p != 1 && p != 4);
			rx_idle = (p != 2 && p != 4);
			run_traffic(100);
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		apply_cfg(RST_RANGE_MIN, RST_RANGE_MAX, RST_WIDTH_MIN, RST_WIDTH_MAX, RST_HOLDOFF,
			RST_IR_ENABLE, RST_REARM_BACK);
		run_traffic(80);

		drain_results();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("** pulse_width_trigger_with_holdoff: PASSED **");
		else
			$display("** pulse_width_trigger_with_holdoff: FAILED **");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("** pulse_width_trigger_with_holdoff: FAILED **");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+design
design/pwth_pkg.sv
design/pwth_ultra.sv
design/pwth_ir.sv
design/pulse_width_trigger_with_holdoff.sv
dv/tb_pulse_width_trigger_with_holdoff.sv
